@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define HEPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define HEPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ sv/hepd_pkg.sv @@
// ----------------------------------------------------------------------------
// hepd_pkg
// Types and codes shared by the palette / EHB / HAM pixel decoder.
// ----------------------------------------------------------------------------
package hepd_pkg;

  // Lookup modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_EHB   = 2'd1;
  localparam logic [1:0] MODE_HAM   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOOKUP_MODE    = 2'd0;
  localparam logic [1:0] CFG_IS_AGA         = 2'd1;
  localparam logic [1:0] CFG_OCS_CORRECTION = 2'd2;
  localparam logic [1:0] CFG_PALETTE_SIZE   = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;

  // Item operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  pixel_value;
    logic        line_start;
    logic [7:0]  palette_index;
    logic [31:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] color;
    logic        index_error;
    logic        ocs_correctable;
  } out_item_t;

  // Where the color of a pixel comes from
  typedef enum logic [1:0] {
    SRC_READ = 2'd0,
    SRC_HALF = 2'd1,
    SRC_HAM  = 2'd2
  } src_t;

  // What a HAM pixel does to the held color
  typedef enum logic [2:0] {
    HAM_LOAD  = 3'd0,
    HAM_BLUE  = 3'd1,
    HAM_RED   = 3'd2,
    HAM_GREEN = 3'd3,
    HAM_KEEP  = 3'd4
  } ham_op_t;

  // Front-end decode carried alongside the palette read
  typedef struct packed {
    src_t       src;
    logic       err;
    logic       reload;
    ham_op_t    ham_op;
    logic [7:0] mv;
  } fe_ctrl_t;

endpackage

@@ sv/hepd_ram.sv @@
// ----------------------------------------------------------------------------
// hepd_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module hepd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/hepd_front.sv @@
// ----------------------------------------------------------------------------
// hepd_front
// Pixel decode ahead of the palette read: picks the read address, flags
// out-of-range reads and works out the HAM action and modify value.
// ----------------------------------------------------------------------------
module hepd_front (
  input  hepd_pkg::in_item_t         item,
  input  logic [1:0]                 lookup_mode,
  input  logic                       is_aga,
  input  logic [hepd_pkg::SIZE_W-1:0] size_in_use,
  output logic [7:0]                 rd_addr,
  output hepd_pkg::fe_ctrl_t         ctrl
);
  import hepd_pkg::*;

  logic [SIZE_W-1:0] pix_ext;
  logic [7:0]        ehb_addr;
  logic              ehb_err;
  logic [3:0]        flag;

  assign pix_ext  = SIZE_W'(item.pixel_value);
  assign ehb_addr = item.pixel_value - 8'd32;
  assign ehb_err  = SIZE_W'(ehb_addr) >= size_in_use;
  assign flag     = is_aga ? {2'b00, item.pixel_value[7:6]} : item.pixel_value[7:4];

  always_comb begin
    rd_addr     = item.pixel_value;
    ctrl.src    = SRC_READ;
    ctrl.err    = pix_ext >= size_in_use;
    ctrl.reload = 1'b0;
    ctrl.ham_op = HAM_KEEP;
    ctrl.mv     = is_aga ? {item.pixel_value[5:0], item.pixel_value[5:4]}
                         : {item.pixel_value[3:0], item.pixel_value[3:0]};
    case (lookup_mode)
      MODE_EHB: begin
        if (pix_ext < size_in_use) begin
          ctrl.err = 1'b0;
        end else if (item.pixel_value >= 8'd32) begin
          rd_addr  = ehb_addr;
          ctrl.err = ehb_err;
          ctrl.src = ehb_err ? SRC_READ : SRC_HALF;
        end else begin
          // below 32 there is no half-brite source
          ctrl.err = 1'b1;
        end
      end
      MODE_HAM: begin
        ctrl.src = SRC_HAM;
        ctrl.err = 1'b0;
        if ((flag != 4'd0) && item.line_start) begin
          ctrl.reload = 1'b1;
          rd_addr     = 8'd0;
          ctrl.err    = size_in_use == '0;
        end
        case (flag)
          4'd0: begin
            ctrl.ham_op = HAM_LOAD;
            ctrl.err    = pix_ext >= size_in_use;
          end
          4'd1:    ctrl.ham_op = HAM_BLUE;
          4'd2:    ctrl.ham_op = HAM_RED;
          4'd3:    ctrl.ham_op = HAM_GREEN;
          default: ctrl.ham_op = HAM_KEEP;
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/hepd_back.sv @@
// ----------------------------------------------------------------------------
// hepd_back
// Color composition after the palette read: OCS nibble fix, half brite and
// the hold-and-modify channel update.
// ----------------------------------------------------------------------------
module hepd_back (
  input  hepd_pkg::fe_ctrl_t ctrl,
  input  logic [31:0]        rd_data,
  input  logic               ocs_correction,
  input  logic [31:0]        held,
  output logic [31:0]        color
);
  import hepd_pkg::*;

  localparam logic [31:0] HIGH_NIBBLES = 32'h00f0f0f0;
  localparam logic [31:0] ALPHA_ONE    = 32'hff000000;
  localparam logic [31:0] HALF_MASK    = 32'hff777777;
  localparam logic [31:0] KEEP_BLUE    = 32'hff00ffff;
  localparam logic [31:0] KEEP_RED     = 32'hffffff00;
  localparam logic [31:0] KEEP_GREEN   = 32'hffff00ff;

  logic [31:0] rd_val;
  logic [31:0] base;

  always_comb begin
    rd_val = rd_data;
    if (ocs_correction) begin
      rd_val = rd_data | ((rd_data & HIGH_NIBBLES) >> 4);
    end
    if (ctrl.err) begin
      rd_val = '0;
    end
    base = ctrl.reload ? rd_val : held;
    case (ctrl.src)
      SRC_HALF: color = ((rd_val >> 1) | ALPHA_ONE) & HALF_MASK;
      SRC_HAM: begin
        case (ctrl.ham_op)
          HAM_LOAD:  color = rd_val;
          HAM_BLUE:  color = (base & KEEP_BLUE) | {8'h00, ctrl.mv, 16'h0000};
          HAM_RED:   color = (base & KEEP_RED) | {24'h000000, ctrl.mv};
          HAM_GREEN: color = (base & KEEP_GREEN) | {16'h0000, ctrl.mv, 8'h00};
          default:   color = base;
        endcase
      end
      default: color = rd_val;
    endcase
  end

endmodule

@@ sv/ham_ehb_palette_pixel_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ham_ehb_palette_pixel_decoder_core
// Indexed pixel to 32-bit color (red in the low byte) through a loadable
// palette, with plain, extra-half-brite and HAM6/HAM8 modes.
// ----------------------------------------------------------------------------
// One item per clock unless stalled; every item is a transfer on in_:
// a palette write (operation 0) yields no result, a pixel (operation 1)
// yields exactly one result, in order. A pixel passes the input register,
// the registered palette read of stage 2 and the output register, which
// drives out_valid.
// The path is input register -> palette RAM read (registered) -> color
// compose into the output register; the HAM held color loops inside the
// compose stage, so back-to-back HAM pixels need no gap. A palette write
// lands in the RAM as it leaves the input register, so a pixel right behind
// it already sees the new entry. Any item, write or pixel, leaves the input
// register only when stage 2 is empty or moving on, so a write never gets
// ahead of a pixel stalled in stage 2. The "correctable" flag comes from a
// per-entry low-nibble bit vector, masked by the palette size and ORed
// through one registered 16-bit group stage. No clearing pass after reset:
// palette entries are undefined until written. cfg_ writes apply the next
// clock; the user must make them only while the block is idle, unchecked.
// ----------------------------------------------------------------------------
module ham_ehb_palette_pixel_decoder_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hepd_pkg::in_item_t                in_item,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output hepd_pkg::out_item_t               out_item,
  // configuration
  input  logic                              cfg_we,
  input  logic [hepd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hepd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hepd_pkg::*;

  `include "assert_macros.svh"

  localparam int              AW      = $clog2(PALETTE_DEPTH);
  localparam logic [SIZE_W-1:0] DEPTH_W = SIZE_W'(PALETTE_DEPTH);
  localparam int              GRP     = 16;
  localparam int              NGRP    = (PALETTE_DEPTH + GRP - 1) / GRP;
  localparam int              LNS_W   = NGRP * GRP;

  // config registers
  logic [1:0]        lookup_mode_r;
  logic              is_aga_r;
  logic              ocs_correction_r;
  logic [SIZE_W-1:0] palette_size_r;
  logic [SIZE_W-1:0] size_in_use;

  // stage 1: input register
  logic              s1_vld_r;
  in_item_t          s1_item_r;
  logic              s1_is_pixel;
  logic              s1_go;

  // stage 2: palette read in flight
  logic              s2_vld_r;
  fe_ctrl_t          s2_ctrl_r;
  fe_ctrl_t          fe_ctrl;
  logic [7:0]        fe_addr;
  logic              s2_move;

  // output register
  logic              out_vld_r;
  out_item_t         out_item_r;
  logic              out_free;

  // palette and low-nibble tracking
  logic              ram_we;
  logic              ram_re;
  logic [31:0]       ram_rdata;
  logic [LNS_W-1:0]  lns_r;
  logic [NGRP-1:0]   grp_any_r;
  logic [NGRP-1:0]   grp_any_nxt;

  // HAM held color
  logic [31:0]       held_r;
  logic [31:0]       color_c;

  assign size_in_use = (palette_size_r < DEPTH_W) ? palette_size_r : DEPTH_W;

  // transfer flow, ready chains back from the output register
  assign out_free    = !out_vld_r || !out_stall;
  assign s2_move     = s2_vld_r && out_free;
  assign s1_is_pixel = s1_item_r.operation == OP_PIXEL;
  // writes wait like pixels: the low-nibble bits seen by a pixel in stage 2
  // must not pick up writes that came in after it
  assign s1_go       = s1_vld_r && (!s2_vld_r || out_free);
  assign in_stall    = s1_vld_r && !s1_go;

  assign ram_we = s1_go && !s1_is_pixel &&
                  (SIZE_W'(s1_item_r.palette_index) < DEPTH_W);
  assign ram_re = s1_go && s1_is_pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_mode_r    <= MODE_PLAIN;
      is_aga_r         <= 1'b0;
      ocs_correction_r <= 1'b0;
      palette_size_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOOKUP_MODE:    lookup_mode_r    <= cfg_data[1:0];
        CFG_IS_AGA:         is_aga_r         <= cfg_data[0];
        CFG_OCS_CORRECTION: ocs_correction_r <= cfg_data[0];
        CFG_PALETTE_SIZE:   palette_size_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!s1_vld_r || s1_go) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  hepd_front u_front (
    .item        (s1_item_r),
    .lookup_mode (lookup_mode_r),
    .is_aga      (is_aga_r),
    .size_in_use (size_in_use),
    .rd_addr     (fe_addr),
    .ctrl        (fe_ctrl)
  );

  hepd_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_item_r.palette_index[AW-1:0]),
    .wdata (s1_item_r.palette_color),
    .re    (ram_re),
    .raddr (fe_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // low-nibble bit per entry; written with the palette
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lns_r <= '0;
    end else if (ram_we) begin
      lns_r[s1_item_r.palette_index[AW-1:0]] <=
        (s1_item_r.palette_color & 32'h000f0f0f) != 32'h0;
    end
  end

  // first OR level, masked by the size in use; runs every clock
  always_comb begin
    grp_any_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int b = 0; b < GRP; b++) begin
        if (lns_r[g*GRP + b] && (SIZE_W'(g*GRP + b) < size_in_use)) begin
          grp_any_nxt[g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_any_r <= '0;
    end else begin
      grp_any_r <= grp_any_nxt;
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ram_re) begin
      s2_vld_r <= 1'b1;
    end else if (s2_move) begin
      s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s2_ctrl_r <= fe_ctrl;
    end
  end

  hepd_back u_back (
    .ctrl           (s2_ctrl_r),
    .rd_data        (ram_rdata),
    .ocs_correction (ocs_correction_r),
    .held           (held_r),
    .color          (color_c)
  );

  // held color only moves on a HAM pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (s2_move && (s2_ctrl_r.src == SRC_HAM)) begin
      held_r <= color_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_item_r.color           <= color_c;
      out_item_r.index_error     <= s2_ctrl_r.err;
      out_item_r.ocs_correctable <= !is_aga_r && !(|grp_any_r);
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  `HEPD_ASSERT(a_held_only_on_ham,
    $past(rst_n) && !$stable(held_r) |-> $past(s2_move && (s2_ctrl_r.src == SRC_HAM)),
    "held color changed without a HAM pixel")
  `HEPD_ASSERT(a_result_from_stage2,
    $rose(out_vld_r) |-> $past(s2_vld_r),
    "result appeared without a pixel in stage 2")
  `HEPD_ASSERT(a_stage2_holds,
    s2_vld_r && !out_free |=> $stable(s2_ctrl_r) && s2_vld_r,
    "stalled pixel in stage 2 changed")
  `HEPD_ASSERT(a_ram_one_access,
    !(ram_we && ram_re),
    "palette read and write in one clock")
  `HEPD_ASSERT_ALWAYS(a_reset_clears_out,
    !rst_n |=> !out_vld_r,
    "result valid right after reset")

endmodule
